FILE: hdl/tlex_pkg.sv
// shared types, constants and transition function for the table-driven lexer
`timescale 1ns / 1ps

package tlex_pkg;

  typedef enum logic [11:0] {
    ST_INIT   = 12'h001,
    ST_INT    = 12'h002,
    ST_IDENT  = 12'h004,
    ST_CMP1   = 12'h008,
    ST_CMP2   = 12'h010,
    ST_BANG   = 12'h020,
    ST_NEQ    = 12'h040,
    ST_SEP    = 12'h080,
    ST_PLUS   = 12'h100,
    ST_MINUS  = 12'h200,
    ST_DBL    = 12'h400,
    ST_MULDIV = 12'h800
  } lex_state_e;

  typedef enum logic [3:0] {
    CL_DELIM  = 4'd0,
    CL_ZERO   = 4'd1,
    CL_DIGIT  = 4'd2,
    CL_ALPHA  = 4'd3,
    CL_SEP    = 4'd4,
    CL_PLUS   = 4'd5,
    CL_MINUS  = 4'd6,
    CL_MULDIV = 4'd7,
    CL_EQ     = 4'd8,
    CL_GTLT   = 4'd9,
    CL_BANG   = 4'd10,
    CL_BAD    = 4'd11
  } char_class_e;

  typedef enum logic [1:0] {
    ACT_GO  = 2'd0,
    ACT_FIN = 2'd1,
    ACT_ERR = 2'd2
  } step_act_e;

  typedef struct packed {
    step_act_e  act;
    lex_state_e nxt;
  } trans_t;

  typedef logic [7:0] char_t;

  // longest keyword; only this many leading characters are ever inspected
  localparam int unsigned KW_MAX_LEN = 6;

  typedef struct packed {
    lex_state_e                 state;
    char_t [KW_MAX_LEN-1:0]     chars;
    logic [2:0]                 short_len;  // 7 means longer than any keyword
  } tok_info_t;

  localparam logic [4:0] KIND_INT     = 5'd0;
  localparam logic [4:0] KIND_IDENT   = 5'd1;
  localparam logic [4:0] KIND_DEFINE  = 5'd2;
  localparam logic [4:0] KIND_WHILE   = 5'd3;
  localparam logic [4:0] KIND_FOR     = 5'd4;
  localparam logic [4:0] KIND_IF      = 5'd5;
  localparam logic [4:0] KIND_ELSE    = 5'd6;
  localparam logic [4:0] KIND_BREAK   = 5'd7;
  localparam logic [4:0] KIND_ADD     = 5'd8;
  localparam logic [4:0] KIND_SUB     = 5'd9;
  localparam logic [4:0] KIND_MUL     = 5'd10;
  localparam logic [4:0] KIND_DIV     = 5'd11;
  localparam logic [4:0] KIND_ASSIGN  = 5'd12;
  localparam logic [4:0] KIND_GT      = 5'd13;
  localparam logic [4:0] KIND_LT      = 5'd14;
  localparam logic [4:0] KIND_GE      = 5'd15;
  localparam logic [4:0] KIND_LE      = 5'd16;
  localparam logic [4:0] KIND_EQ      = 5'd17;
  localparam logic [4:0] KIND_NE      = 5'd18;
  localparam logic [4:0] KIND_INC     = 5'd19;
  localparam logic [4:0] KIND_DEC     = 5'd20;
  localparam logic [4:0] KIND_LPAREN  = 5'd21;
  localparam logic [4:0] KIND_RPAREN  = 5'd22;
  localparam logic [4:0] KIND_LBRACK  = 5'd23;
  localparam logic [4:0] KIND_RBRACK  = 5'd24;
  localparam logic [4:0] KIND_LBRACE  = 5'd25;
  localparam logic [4:0] KIND_RBRACE  = 5'd26;
  localparam logic [4:0] KIND_SEMI    = 5'd27;
  localparam logic [4:0] KIND_COMMA   = 5'd28;
  localparam logic [4:0] KIND_ERROR   = 5'd29;

  localparam logic [47:0] KW_DEFINE = "define";
  localparam logic [39:0] KW_WHILE  = "while";
  localparam logic [23:0] KW_FOR    = "for";
  localparam logic [15:0] KW_IF     = "if";
  localparam logic [31:0] KW_ELSE   = "else";
  localparam logic [39:0] KW_BREAK  = "break";

  function automatic trans_t next_of(lex_state_e st, char_class_e cls);
    trans_t t;
    t.act = ACT_FIN;
    t.nxt = ST_INIT;
    unique case (st)
      ST_INIT: begin
        t.act = ACT_GO;
        unique case (cls)
          CL_DELIM:           t.nxt = ST_INIT;
          CL_ZERO, CL_DIGIT:  t.nxt = ST_INT;
          CL_ALPHA:           t.nxt = ST_IDENT;
          CL_SEP:             t.nxt = ST_SEP;
          CL_PLUS:            t.nxt = ST_PLUS;
          CL_MINUS:           t.nxt = ST_MINUS;
          CL_MULDIV:          t.nxt = ST_MULDIV;
          CL_EQ, CL_GTLT:     t.nxt = ST_CMP1;
          CL_BANG:            t.nxt = ST_BANG;
          default:            t.act = ACT_ERR;
        endcase
      end
      ST_INT: begin
        if (cls == CL_ZERO || cls == CL_DIGIT) begin
          t.act = ACT_GO;
          t.nxt = ST_INT;
        end else if (cls == CL_ALPHA) begin
          t.act = ACT_ERR;
        end
      end
      ST_IDENT: begin
        if (cls == CL_ZERO || cls == CL_DIGIT || cls == CL_ALPHA) begin
          t.act = ACT_GO;
          t.nxt = ST_IDENT;
        end
      end
      ST_CMP1: begin
        if (cls == CL_EQ) begin
          t.act = ACT_GO;
          t.nxt = ST_CMP2;
        end
      end
      ST_BANG: begin
        if (cls == CL_EQ) begin
          t.act = ACT_GO;
          t.nxt = ST_NEQ;
        end else if (cls != CL_DELIM) begin
          t.act = ACT_ERR;
        end
      end
      ST_PLUS: begin
        if (cls == CL_PLUS) begin
          t.act = ACT_GO;
          t.nxt = ST_DBL;
        end
      end
      ST_MINUS: begin
        if (cls == CL_MINUS) begin
          t.act = ACT_GO;
          t.nxt = ST_DBL;
        end
      end
      default: ;
    endcase
    if (cls == CL_BAD) begin
      t.act = ACT_ERR;
      t.nxt = ST_INIT;
    end
    return t;
  endfunction

endpackage

FILE: hdl/tlex_classify.sv
// character class decoder
`timescale 1ns / 1ps

module tlex_classify (
  input  logic [7:0]                char_i,
  output tlex_pkg::char_class_e     class_o
);

  always_comb begin
    priority if (char_i == 8'h20 || char_i == 8'h09 || char_i == 8'h0a) begin
      class_o = tlex_pkg::CL_DELIM;
    end else if (char_i == "0") begin
      class_o = tlex_pkg::CL_ZERO;
    end else if (char_i >= "1" && char_i <= "9") begin
      class_o = tlex_pkg::CL_DIGIT;
    end else if ((char_i >= "a" && char_i <= "z") || (char_i >= "A" && char_i <= "Z")) begin
      class_o = tlex_pkg::CL_ALPHA;
    end else if (char_i == ";" || char_i == "(" || char_i == ")" || char_i == "[" ||
                 char_i == "]" || char_i == "{" || char_i == "}" || char_i == ",") begin
      class_o = tlex_pkg::CL_SEP;
    end else if (char_i == "+") begin
      class_o = tlex_pkg::CL_PLUS;
    end else if (char_i == "-") begin
      class_o = tlex_pkg::CL_MINUS;
    end else if (char_i == "*" || char_i == "/") begin
      class_o = tlex_pkg::CL_MULDIV;
    end else if (char_i == "=") begin
      class_o = tlex_pkg::CL_EQ;
    end else if (char_i == ">" || char_i == "<") begin
      class_o = tlex_pkg::CL_GTLT;
    end else if (char_i == "!") begin
      class_o = tlex_pkg::CL_BANG;
    end else begin
      class_o = tlex_pkg::CL_BAD;
    end
  end

endmodule

FILE: hdl/tlex_kind.sv
// token kind decoder with keyword match
`timescale 1ns / 1ps

module tlex_kind (
  input  tlex_pkg::tok_info_t info_i,
  output logic [4:0]          kind_o
);

  tlex_pkg::char_t first;
  logic [4:0]      ident_kind;

  assign first = info_i.chars[0];

  always_comb begin
    priority if (info_i.short_len == 3'd6 &&
                 {info_i.chars[0], info_i.chars[1], info_i.chars[2], info_i.chars[3],
                  info_i.chars[4], info_i.chars[5]} == tlex_pkg::KW_DEFINE) begin
      ident_kind = tlex_pkg::KIND_DEFINE;
    end else if (info_i.short_len == 3'd5 &&
                 {info_i.chars[0], info_i.chars[1], info_i.chars[2], info_i.chars[3],
                  info_i.chars[4]} == tlex_pkg::KW_WHILE) begin
      ident_kind = tlex_pkg::KIND_WHILE;
    end else if (info_i.short_len == 3'd3 &&
                 {info_i.chars[0], info_i.chars[1], info_i.chars[2]} == tlex_pkg::KW_FOR) begin
      ident_kind = tlex_pkg::KIND_FOR;
    end else if (info_i.short_len == 3'd2 &&
                 {info_i.chars[0], info_i.chars[1]} == tlex_pkg::KW_IF) begin
      ident_kind = tlex_pkg::KIND_IF;
    end else if (info_i.short_len == 3'd4 &&
                 {info_i.chars[0], info_i.chars[1], info_i.chars[2],
                  info_i.chars[3]} == tlex_pkg::KW_ELSE) begin
      ident_kind = tlex_pkg::KIND_ELSE;
    end else if (info_i.short_len == 3'd5 &&
                 {info_i.chars[0], info_i.chars[1], info_i.chars[2], info_i.chars[3],
                  info_i.chars[4]} == tlex_pkg::KW_BREAK) begin
      ident_kind = tlex_pkg::KIND_BREAK;
    end else begin
      ident_kind = tlex_pkg::KIND_IDENT;
    end
  end

  always_comb begin
    kind_o = tlex_pkg::KIND_ERROR;
    unique case (info_i.state)
      tlex_pkg::ST_INT:    kind_o = tlex_pkg::KIND_INT;
      tlex_pkg::ST_IDENT:  kind_o = ident_kind;
      tlex_pkg::ST_PLUS:   kind_o = tlex_pkg::KIND_ADD;
      tlex_pkg::ST_MINUS:  kind_o = tlex_pkg::KIND_SUB;
      tlex_pkg::ST_MULDIV: kind_o = (first == "*") ? tlex_pkg::KIND_MUL : tlex_pkg::KIND_DIV;
      tlex_pkg::ST_CMP1: begin
        priority if (first == "=") kind_o = tlex_pkg::KIND_ASSIGN;
        else if (first == ">")     kind_o = tlex_pkg::KIND_GT;
        else                       kind_o = tlex_pkg::KIND_LT;
      end
      tlex_pkg::ST_CMP2: begin
        priority if (first == ">") kind_o = tlex_pkg::KIND_GE;
        else if (first == "<")     kind_o = tlex_pkg::KIND_LE;
        else                       kind_o = tlex_pkg::KIND_EQ;
      end
      tlex_pkg::ST_NEQ:    kind_o = tlex_pkg::KIND_NE;
      tlex_pkg::ST_DBL:    kind_o = (first == "+") ? tlex_pkg::KIND_INC : tlex_pkg::KIND_DEC;
      tlex_pkg::ST_SEP: begin
        priority if (first == "(") kind_o = tlex_pkg::KIND_LPAREN;
        else if (first == ")")     kind_o = tlex_pkg::KIND_RPAREN;
        else if (first == "[")     kind_o = tlex_pkg::KIND_LBRACK;
        else if (first == "]")     kind_o = tlex_pkg::KIND_RBRACK;
        else if (first == "{")     kind_o = tlex_pkg::KIND_LBRACE;
        else if (first == "}")     kind_o = tlex_pkg::KIND_RBRACE;
        else if (first == ";")     kind_o = tlex_pkg::KIND_SEMI;
        else                       kind_o = tlex_pkg::KIND_COMMA;
      end
      default: kind_o = tlex_pkg::KIND_ERROR;
    endcase
  end

endmodule

FILE: hdl/token_lexer_dfa_core.sv
// Table-driven lexer core: one character per transaction, one token result per finished token.
//
// Input channel: char_code_i and end_of_input_i with in_valid_i / in_stall_o. A
// transaction with end_of_input_i set acts as a delimiter and flushes a pending token.
// Output channel: token_kind_o and token_length_o with out_valid_o / out_stall_i. A
// character produces zero or one result.
// Datapath: a character enters an input register, is classified, stepped through the
// transition function and keyword decode combinationally, and its result is written
// to the output register that drives out_valid_o.
// Throughput: one character per cycle unless the output stalls; the only loop is the
// lexer state, length and leading-character registers, updated in the same cycle the character is processed.
// A stalled output holds its result; the input register then fills and in_stall_o
// rises in the same cycle, with no bubble once out_stall_i drops.
// Reset: lexer returns to the initial state with an empty token, both registers empty.
// Tokens longer than MAX_TOKEN_CHARS give an error result and restart the lexer.
`timescale 1ns / 1ps

module token_lexer_dfa_core #(
  parameter int unsigned MAX_TOKEN_CHARS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_code_i,
  input  logic       end_of_input_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [4:0] token_kind_o,
  output logic [5:0] token_length_o
);

  localparam int unsigned LenRawW = $clog2(MAX_TOKEN_CHARS + 1);
  localparam int unsigned LenW    = (LenRawW < 6) ? 6 : LenRawW;
  localparam logic [5:0]  OvfLen  = (MAX_TOKEN_CHARS > 63) ? 6'd63 : 6'(MAX_TOKEN_CHARS);

  logic                    in_valid_q;
  logic [7:0]              char_q;
  logic                    eoi_q;
  logic                    out_valid_q, out_valid_d;
  logic [4:0]              kind_q, kind_d;
  logic [5:0]              length_q, length_d;

  tlex_pkg::lex_state_e    state_q, state_d;
  logic [LenW-1:0]         len_q, len_d;
  tlex_pkg::char_t [tlex_pkg::KW_MAX_LEN-1:0] chars_q, chars_d;

  logic                    adv;
  logic                    emit;
  tlex_pkg::char_class_e   cls_raw, cls;
  tlex_pkg::trans_t        tr, tr0;
  tlex_pkg::tok_info_t     info;
  logic [4:0]              tok_kind;
  logic [LenW-1:0]         len_inc;
  logic [5:0]              len_sat, inc_sat;

  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !adv;

  tlex_classify u_classify (
    .char_i  (char_q),
    .class_o (cls_raw)
  );

  assign cls = eoi_q ? tlex_pkg::CL_DELIM : cls_raw;
  assign tr  = tlex_pkg::next_of(state_q, cls);
  assign tr0 = tlex_pkg::next_of(tlex_pkg::ST_INIT, cls);

  assign info.state     = state_q;
  assign info.chars     = chars_q;
  assign info.short_len = (len_q > LenW'(tlex_pkg::KW_MAX_LEN)) ? 3'd7 : len_q[2:0];

  tlex_kind u_kind (
    .info_i (info),
    .kind_o (tok_kind)
  );

  assign len_inc = len_q + LenW'(1);
  assign len_sat = (len_q > LenW'(63)) ? 6'd63 : len_q[5:0];
  assign inc_sat = (len_q == LenW'(MAX_TOKEN_CHARS)) ? OvfLen :
                   (len_inc > LenW'(63)) ? 6'd63 : len_inc[5:0];

  always_comb begin
    state_d  = state_q;
    len_d    = len_q;
    chars_d  = chars_q;
    emit     = 1'b0;
    kind_d   = kind_q;
    length_d = length_q;
    if (in_valid_q && adv) begin
      unique case (tr.act)
        tlex_pkg::ACT_FIN: begin
          emit     = 1'b1;
          kind_d   = tok_kind;
          length_d = len_sat;
          if (cls != tlex_pkg::CL_DELIM && tr0.act == tlex_pkg::ACT_GO) begin
            chars_d[0] = char_q;
            len_d      = LenW'(1);
            state_d    = tr0.nxt;
          end else begin
            len_d   = '0;
            state_d = tlex_pkg::ST_INIT;
          end
        end
        tlex_pkg::ACT_ERR: begin
          emit     = 1'b1;
          kind_d   = tlex_pkg::KIND_ERROR;
          length_d = inc_sat;
          len_d    = '0;
          state_d  = tlex_pkg::ST_INIT;
        end
        tlex_pkg::ACT_GO: begin
          state_d = tr.nxt;
          if (cls != tlex_pkg::CL_DELIM) begin
            if (len_q >= LenW'(MAX_TOKEN_CHARS)) begin
              emit     = 1'b1;
              kind_d   = tlex_pkg::KIND_ERROR;
              length_d = OvfLen;
              len_d    = '0;
              state_d  = tlex_pkg::ST_INIT;
            end else begin
              if (len_q < LenW'(tlex_pkg::KW_MAX_LEN)) begin
                chars_d[len_q[2:0]] = char_q;
              end
              len_d = len_inc;
            end
          end
        end
        default: ;
      endcase
    end
    out_valid_d = adv ? emit : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= tlex_pkg::ST_INIT;
      len_q       <= '0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      out_valid_q <= out_valid_d;
      state_q     <= state_d;
      len_q       <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o) begin
      char_q <= char_code_i;
      eoi_q  <= end_of_input_i;
    end
    chars_q  <= chars_d;
    kind_q   <= kind_d;
    length_q <= length_d;
  end

  assign out_valid_o    = out_valid_q;
  assign token_kind_o   = kind_q;
  assign token_length_o = length_q;

endmodule

FILE: hdl/tlex_checker.sv
// port-level checker for the lexer core, bound into token_lexer_dfa_core
`timescale 1ns / 1ps

module tlex_port_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [7:0] char_code_i,
  input logic       end_of_input_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [4:0] token_kind_o,
  input logic [5:0] token_length_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(token_kind_o) &&
                                   $stable(token_length_o))
    else $error("stalled result changed");

  // every result carries a legal kind and a nonzero length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> token_kind_o <= tlex_pkg::KIND_ERROR && token_length_o != 6'd0)
    else $error("result kind or length out of range");

  // a stalled input transaction holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(char_code_i) &&
                                 $stable(end_of_input_i))
    else $error("stalled input changed");

  // two-character operators
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_kind_o >= tlex_pkg::KIND_GE && token_kind_o <= tlex_pkg::KIND_DEC
    |-> token_length_o == 6'd2)
    else $error("two-character operator length mismatch");

  // single-character operators and separators
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((token_kind_o >= tlex_pkg::KIND_ADD && token_kind_o <= tlex_pkg::KIND_LT) ||
                    (token_kind_o >= tlex_pkg::KIND_LPAREN &&
                     token_kind_o <= tlex_pkg::KIND_COMMA))
    |-> token_length_o == 6'd1)
    else $error("single-character token length mismatch");

endmodule

bind token_lexer_dfa_core tlex_port_checker u_tlex_port_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .char_code_i    (char_code_i),
  .end_of_input_i (end_of_input_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .token_kind_o   (token_kind_o),
  .token_length_o (token_length_o)
);
